@@ sv/tdts_pkg.sv @@
// Shared constants, item types and state codes for the tick-driven task scheduler.
`default_nettype none

package tdts_pkg;

  localparam int NUM_TASKS    = 8;
  localparam int COUNTER_BITS = 16;
  localparam int TASK_W       = (NUM_TASKS > 2) ? $clog2(NUM_TASKS) : 1;
  localparam int PRI_W        = 16;
  localparam int LFSR_W       = 16;
  localparam int SUM_W        = ((COUNTER_BITS > PRI_W) ? COUNTER_BITS : PRI_W) + 1;
  localparam int CFG_IDX_W    = 2;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

  localparam logic [TASK_W-1:0] IDLE_TASK = '0;
  localparam logic [TASK_W-1:0] FIRST_TASK = TASK_W'(1);
  localparam logic [TASK_W-1:0] LAST_TASK = TASK_W'(NUM_TASKS - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SEED   = CFG_IDX_W'(1);

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  localparam logic MODE_PRIORITY = 1'b0;
  localparam logic MODE_SHORTEST = 1'b1;

  typedef struct packed {
    logic        action;
    logic [2:0]  task_index;
    logic [15:0] counter_value;
    logic [15:0] priority_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  running_task;
    logic        switched;
    logic        refilled;
    logic        stuck;
    logic [15:0] running_counter;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DEC    = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_REFILL = 5'b01000,
    ST_FIN    = 5'b10000
  } state_t;

endpackage

`default_nettype wire

@@ sv/tdts_alu.sv @@
// Shared arithmetic unit: decrement, scan compare, refill value and LFSR step.
`default_nettype none

module tdts_alu (
  input  wire logic                              mode,
  input  wire logic [tdts_pkg::COUNTER_BITS-1:0] cnt,
  input  wire logic [tdts_pkg::COUNTER_BITS-1:0] best,
  input  wire logic                              pick_zero,
  input  wire logic [tdts_pkg::PRI_W-1:0]        pri,
  input  wire logic [tdts_pkg::LFSR_W-1:0]       lfsr,
  output logic      [tdts_pkg::COUNTER_BITS-1:0] dec_val,
  output logic                                   better,
  output logic      [tdts_pkg::COUNTER_BITS-1:0] refill_val,
  output logic      [tdts_pkg::LFSR_W-1:0]       lfsr_nxt
);
  import tdts_pkg::*;

  logic [SUM_W-1:0] sum;

  assign dec_val = (cnt == '0) ? '0 : cnt - COUNTER_BITS'(1);

  always_comb begin
    if (mode == MODE_PRIORITY) begin
      better = (cnt != '0) && (cnt >= best);
    end else begin
      better = (cnt != '0) && (pick_zero || (cnt < best));
    end
  end

  assign lfsr_nxt = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : '0);
  assign sum = SUM_W'(cnt >> 1) + SUM_W'(pri);

  always_comb begin
    if (mode == MODE_PRIORITY) begin
      refill_val = (sum > SUM_W'(CNT_MAX)) ? CNT_MAX : COUNTER_BITS'(sum);
    end else begin
      refill_val = COUNTER_BITS'(lfsr_nxt);
    end
  end

endmodule

`default_nettype wire

@@ sv/tick_driven_task_scheduler.sv @@
// Top level of the tick-driven task scheduler: task table, sequencer and ports.
`default_nettype none

// One item is handled at a time by a sequencer that steps through the task table one entry
// per cycle with a single shared compare/add unit. A load item writes the table, then finishes.
// A tick decrements the running task and finishes if it still has time, rescans entries
// 1 to N-1 (N = NUM_TASKS) once it runs out, and adds a refill pass and a second scan when
// the first scan finds no task with time left; a tick taken while the idle task runs skips
// the decrement. Input is taken again once the result sits in the output register; the
// output register holds one finished result while the next item is worked on.
module tick_driven_task_scheduler (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire tdts_pkg::in_item_t                    in_data,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output tdts_pkg::out_item_t                        out_data,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [tdts_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [15:0]                           cfg_data
);
  import tdts_pkg::*;

  logic [COUNTER_BITS-1:0] cnt_r [NUM_TASKS];
  logic [PRI_W-1:0]        pri_r [NUM_TASKS];

  state_t              state_r, state_nxt;
  logic [TASK_W-1:0]   cur_r, cur_nxt;
  logic [TASK_W-1:0]   prev_r, prev_nxt;
  logic [TASK_W-1:0]   idx_r, idx_nxt;
  logic [TASK_W-1:0]   pick_r, pick_nxt;
  logic [COUNTER_BITS-1:0] best_r, best_nxt;
  logic                refilled_r, refilled_nxt;
  logic                stuck_r, stuck_nxt;
  logic                mode_r;
  logic [LFSR_W-1:0]   lfsr_r, lfsr_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic                in_xfer, cfg_xfer, out_free;
  logic [TASK_W-1:0]   rd_idx;
  logic [COUNTER_BITS-1:0] rd_cnt;
  logic                wr_en;
  logic [TASK_W-1:0]   wr_idx;
  logic [COUNTER_BITS-1:0] wr_cnt;
  logic                wr_pri_en;
  logic [PRI_W-1:0]    wr_pri;

  logic [COUNTER_BITS-1:0] dec_val, refill_val;
  logic                better;
  logic [LFSR_W-1:0]   lfsr_step;
  logic                load_ok;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rd_idx = (state_r == ST_DEC || state_r == ST_FIN) ? cur_r : idx_r;
  assign rd_cnt = cnt_r[rd_idx];
  assign load_ok = (in_data.task_index != 3'd0) && (int'(in_data.task_index) < NUM_TASKS);

  tdts_alu u_alu (
    .mode       (mode_r),
    .cnt        (rd_cnt),
    .best       (best_r),
    .pick_zero  (pick_r == IDLE_TASK),
    .pri        (pri_r[rd_idx]),
    .lfsr       (lfsr_r),
    .dec_val    (dec_val),
    .better     (better),
    .refill_val (refill_val),
    .lfsr_nxt   (lfsr_step)
  );

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    idx_nxt       = idx_r;
    pick_nxt      = pick_r;
    best_nxt      = best_r;
    refilled_nxt  = refilled_r;
    stuck_nxt     = stuck_r;
    lfsr_nxt      = lfsr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_idx        = rd_idx;
    wr_cnt        = dec_val;
    wr_pri_en     = 1'b0;
    wr_pri        = in_data.priority_value;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          prev_nxt     = cur_r;
          refilled_nxt = 1'b0;
          stuck_nxt    = 1'b0;
          idx_nxt      = FIRST_TASK;
          pick_nxt     = IDLE_TASK;
          best_nxt     = '0;
          if (in_data.action == ACT_LOAD) begin
            wr_en     = load_ok;
            wr_pri_en = load_ok;
            wr_idx    = TASK_W'(in_data.task_index);
            wr_cnt    = COUNTER_BITS'(in_data.counter_value);
            state_nxt = ST_FIN;
          end else if (cur_r == IDLE_TASK) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DEC;
          end
        end
      end
      ST_DEC: begin
        wr_en     = 1'b1;
        wr_cnt    = dec_val;
        state_nxt = (dec_val == '0) ? ST_SCAN : ST_FIN;
      end
      ST_SCAN: begin
        if (better) begin
          pick_nxt = idx_r;
          best_nxt = rd_cnt;
        end
        idx_nxt = idx_r + TASK_W'(1);
        if (idx_r == LAST_TASK) begin
          if (better || pick_r != IDLE_TASK) begin
            cur_nxt   = better ? idx_r : pick_r;
            state_nxt = ST_FIN;
          end else if (!refilled_r) begin
            idx_nxt   = LAST_TASK;
            state_nxt = ST_REFILL;
          end else begin
            stuck_nxt = 1'b1;
            state_nxt = ST_FIN;
          end
        end
      end
      ST_REFILL: begin
        wr_en  = 1'b1;
        wr_cnt = refill_val;
        if (mode_r == MODE_SHORTEST) begin
          lfsr_nxt = lfsr_step;
        end
        idx_nxt = idx_r - TASK_W'(1);
        if (idx_r == FIRST_TASK) begin
          refilled_nxt = 1'b1;
          idx_nxt      = FIRST_TASK;
          pick_nxt     = IDLE_TASK;
          best_nxt     = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.running_task    = 3'(cur_r);
          out_data_nxt.switched        = (cur_r != prev_r);
          out_data_nxt.refilled        = refilled_r;
          out_data_nxt.stuck           = stuck_r;
          out_data_nxt.running_counter = (cur_r == IDLE_TASK) ? 16'd0 : 16'(rd_cnt);
          state_nxt                    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_xfer && cfg_index == CFG_SEED) begin
      lfsr_nxt = (cfg_data == 16'd0) ? LFSR_W'(1) : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= IDLE_TASK;
      prev_r      <= IDLE_TASK;
      idx_r       <= FIRST_TASK;
      pick_r      <= IDLE_TASK;
      best_r      <= '0;
      refilled_r  <= 1'b0;
      stuck_r     <= 1'b0;
      mode_r      <= MODE_PRIORITY;
      lfsr_r      <= LFSR_W'(1);
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        cnt_r[i] <= '0;
        pri_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      prev_r      <= prev_nxt;
      idx_r       <= idx_nxt;
      pick_r      <= pick_nxt;
      best_r      <= best_nxt;
      refilled_r  <= refilled_nxt;
      stuck_r     <= stuck_nxt;
      lfsr_r      <= lfsr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_xfer && cfg_index == CFG_POLICY) begin
        mode_r <= cfg_data[0];
      end
      if (wr_en) begin
        cnt_r[wr_idx] <= wr_cnt;
      end
      if (wr_pri_en) begin
        pri_r[wr_idx] <= wr_pri;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire
